/* hw/rtl/bblur_pkg.sv */
// Shared types, constants and the reciprocal table for the 3x3 box blur.
package bblur_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam int CH_W        = 8;
  localparam int NUM_CH      = 3;
  localparam int PIX_W       = NUM_CH * CH_W;
  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;
  localparam int X_W         = SUM_W + 1;
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = X_W + RECIP_W;

  localparam int OUT_FIFO_DEPTH = 8;

  typedef struct packed {
    logic                          last;
    logic [CNT_W-1:0]              count;
    logic [NUM_CH-1:0][SUM_W-1:0]  sum;
  } sum_item_t;

  typedef struct packed {
    logic                         last;
    logic [NUM_CH-1:0][CH_W-1:0]  chan;
  } res_item_t;

  // ceil(2^16 / (2*count)); exact enough for every sum a 3x3 window can give
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] r;
    unique case (count)
      4'd1:    r = 16'd32768;
      4'd2:    r = 16'd16384;
      4'd3:    r = 16'd10923;
      4'd4:    r = 16'd8192;
      4'd6:    r = 16'd5462;
      4'd9:    r = 16'd3641;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/bblur_mean.sv */
// Rounded mean of the window sums: reciprocal multiply over two register stages.
module bblur_mean (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  bblur_pkg::sum_item_t  in_item,
  output logic                  out_valid,
  output bblur_pkg::res_item_t  out_item,
  output logic [1:0]            inflight
);

  logic                                                     s2_valid_r;
  bblur_pkg::sum_item_t                                     s2_item_r;
  logic                                                     s3_valid_r;
  logic                                                     s3_last_r;
  logic [bblur_pkg::NUM_CH-1:0][bblur_pkg::PROD_W-1:0]      s3_prod_r;
  logic [bblur_pkg::NUM_CH-1:0][bblur_pkg::PROD_W-1:0]      prod;
  logic [bblur_pkg::X_W-1:0]                                x;
  logic [bblur_pkg::RECIP_W-1:0]                            rcp;

  always_comb begin
    rcp = bblur_pkg::recip(s2_item_r.count);
    x   = '0;
    for (int k = 0; k < bblur_pkg::NUM_CH; k++) begin
      x = {s2_item_r.sum[k], 1'b0}
          + {{(bblur_pkg::X_W - bblur_pkg::CNT_W){1'b0}}, s2_item_r.count};
      prod[k] = {{bblur_pkg::RECIP_W{1'b0}}, x}
                * {{bblur_pkg::X_W{1'b0}}, rcp};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= in_valid;
      s3_valid_r <= s2_valid_r;
    end
    s2_item_r <= in_item;
    s3_prod_r <= prod;
    s3_last_r <= s2_item_r.last;
  end

  always_comb begin
    out_item.last = s3_last_r;
    for (int k = 0; k < bblur_pkg::NUM_CH; k++) begin
      out_item.chan[k] = s3_prod_r[k][bblur_pkg::RECIP_SHIFT +: bblur_pkg::CH_W];
    end
  end

  assign out_valid = s3_valid_r;
  assign inflight  = {1'b0, s2_valid_r} + {1'b0, s3_valid_r};

endmodule

/* hw/rtl/bblur_out_fifo.sv */
// Output queue that holds finished results while the result channel stalls.
module bblur_out_fifo #(
  parameter int DEPTH = bblur_pkg::OUT_FIFO_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  bblur_pkg::res_item_t          push_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bblur_pkg::res_item_t          out_item,
  output logic [$clog2(DEPTH+1)-1:0]    level
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W    = $clog2(DEPTH + 1);

  bblur_pkg::res_item_t   entry_r [DEPTH];
  logic [PTR_BITS-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0]       level_r, level_nxt;
  logic                   pop;

  assign out_valid = (level_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_item  = entry_r[rd_ptr_r];
  assign level     = level_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* hw/rtl/box_blur_3x3_edge_clipped_top.sv */
// 3x3 edge-clipped box blur top level: line store, window, position counters.
// Throughput: one transaction per cycle; the last pixel of a one-row frame adds an
//   internal bubble in which the input stalls, and the input stalls while eight results
//   are queued or in flight.
// Path: the transaction that releases a result feeds the window sum, the reciprocal
//   multiply and the output queue; a result trails its pixel by width+1 transactions.
// Reset: positions and frame state clear, width and height read as 1; the line store
//   keeps its contents and needs no clearing pass.
module box_blur_3x3_edge_clipped_top #(
  parameter int MAX_WIDTH  = bblur_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bblur_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bblur_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_req_type,
  input  logic [7:0]                        in_red_in,
  input  logic [7:0]                        in_green_in,
  input  logic [7:0]                        in_blue_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_red_out,
  output logic [7:0]                        out_green_out,
  output logic [7:0]                        out_blue_out,
  output logic                              out_frame_last
);

  localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_BITS = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PIX_W    = bblur_pkg::PIX_W;
  localparam int CH_W     = bblur_pkg::CH_W;
  localparam int SUM_W    = bblur_pkg::SUM_W;
  localparam int FCNT_W   = $clog2(bblur_pkg::OUT_FIFO_DEPTH + 1);
  localparam int LVL_W    = FCNT_W + 2;

  // frame geometry, kept as last column / last row
  logic [COL_BITS-1:0]  w_last_r, w_last_nxt;
  logic [ROW_BITS-1:0]  h_last_r, h_last_nxt;
  logic [31:0]          cfg_w_val, cfg_h_val;
  logic [COL_BITS-1:0]  cfg_w_last;
  logic [ROW_BITS-1:0]  cfg_h_last;

  // positions
  logic [COL_BITS-1:0]  vc_r, vc_nxt;
  logic [ROW_BITS-1:0]  in_row_r, in_row_nxt;
  logic                 in_done_r, in_done_nxt;
  logic                 bubble_r, bubble_nxt;
  logic [COL_BITS-1:0]  out_col_r, out_col_nxt;
  logic [ROW_BITS-1:0]  out_row_r, out_row_nxt;

  logic                 accept, issue, op_pix, op_emit, vc_wrap, frame_end;

  // line store: {row above, row two above} per column
  logic [2*PIX_W-1:0]   line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0]   rd_data_r;
  logic [2*PIX_W-1:0]   fwd_data_r;
  logic [2*PIX_W-1:0]   cur_word, wr_data;

  // read-side stage
  logic                 s1_valid_r, s1_emit_r, s1_last_r, s1_fwd_r;
  logic [PIX_W-1:0]     s1_pix_r;
  logic [COL_BITS-1:0]  s1_col_r;
  logic                 s1_top_r, s1_bot_r, s1_left_r, s1_right_r;

  // window: left and center columns, rows top to bottom
  logic [PIX_W-1:0]     win_l_r [3];
  logic [PIX_W-1:0]     win_c_r [3];
  logic [PIX_W-1:0]     new_col [3];
  logic [2:0]           row_ok;
  logic [SUM_W-1:0]     row_sum [3];
  logic [1:0]           row_n, col_n;

  bblur_pkg::sum_item_t sum_item;
  bblur_pkg::res_item_t mean_item, out_item;
  logic                 mean_valid;
  logic [1:0]           mean_inflight;
  logic [FCNT_W-1:0]    fifo_level;
  logic [LVL_W-1:0]     level_sum;

  // clamp register writes to 1..MAX
  always_comb begin
    cfg_w_val = 32'(cfg_data[bblur_pkg::WIDTH_REG_W-1:0]);
    cfg_h_val = 32'(cfg_data[bblur_pkg::HEIGHT_REG_W-1:0]);
    if (cfg_w_val == 32'd0) begin
      cfg_w_last = '0;
    end else if (cfg_w_val > 32'(MAX_WIDTH)) begin
      cfg_w_last = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      cfg_w_last = COL_BITS'(cfg_w_val - 32'd1);
    end
    if (cfg_h_val == 32'd0) begin
      cfg_h_last = '0;
    end else if (cfg_h_val > 32'(MAX_HEIGHT)) begin
      cfg_h_last = ROW_BITS'(MAX_HEIGHT - 1);
    end else begin
      cfg_h_last = ROW_BITS'(cfg_h_val - 32'd1);
    end
  end

  assign level_sum = LVL_W'(fifo_level) + LVL_W'(mean_inflight)
                     + LVL_W'(s1_valid_r && s1_emit_r);
  assign in_stall  = bubble_r || (level_sum >= LVL_W'(bblur_pkg::OUT_FIFO_DEPTH));

  assign accept  = in_valid && !in_stall;
  assign issue   = bubble_r
                   || (accept && (in_done_r || (in_req_type == bblur_pkg::REQ_PIXEL)));
  assign op_pix  = !bubble_r && !in_done_r;
  assign op_emit = !bubble_r
                   && (in_done_r || (32'(in_row_r) >= 32'd2)
                       || ((in_row_r == ROW_BITS'(1)) && (vc_r != '0)));
  assign vc_wrap   = (vc_r == w_last_r);
  assign frame_end = (out_row_r == h_last_r) && (out_col_r == w_last_r);

  always_comb begin
    w_last_nxt  = w_last_r;
    h_last_nxt  = h_last_r;
    vc_nxt      = vc_r;
    in_row_nxt  = in_row_r;
    in_done_nxt = in_done_r;
    bubble_nxt  = 1'b0;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    priority if (cfg_wr_en) begin
      unique case (bblur_pkg::cfg_reg_t'(cfg_index))
        bblur_pkg::REG_IMAGE_WIDTH:  w_last_nxt = cfg_w_last;
        bblur_pkg::REG_IMAGE_HEIGHT: h_last_nxt = cfg_h_last;
      endcase
      vc_nxt      = '0;
      in_row_nxt  = '0;
      in_done_nxt = 1'b0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (issue) begin
      vc_nxt = vc_wrap ? '0 : vc_r + 1'b1;
      if (op_pix && vc_wrap) begin
        if (in_row_r == h_last_r) begin
          in_row_nxt  = '0;
          in_done_nxt = 1'b1;
          bubble_nxt  = (h_last_r == '0);
        end else begin
          in_row_nxt = in_row_r + 1'b1;
        end
      end
      if (op_emit) begin
        if (frame_end) begin
          vc_nxt      = '0;
          in_row_nxt  = '0;
          in_done_nxt = 1'b0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_col_r == w_last_r) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
      end
    end else begin
      bubble_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r   <= '0;
      h_last_r   <= '0;
      vc_r       <= '0;
      in_row_r   <= '0;
      in_done_r  <= 1'b0;
      bubble_r   <= 1'b0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      s1_valid_r <= 1'b0;
      s1_emit_r  <= 1'b0;
      s1_fwd_r   <= 1'b0;
    end else begin
      w_last_r   <= w_last_nxt;
      h_last_r   <= h_last_nxt;
      vc_r       <= vc_nxt;
      in_row_r   <= in_row_nxt;
      in_done_r  <= in_done_nxt;
      bubble_r   <= bubble_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      s1_valid_r <= issue;
      s1_emit_r  <= issue && op_emit;
      if (issue) begin
        s1_fwd_r <= s1_valid_r && (s1_col_r == vc_r);
      end
    end
    if (issue) begin
      s1_pix_r   <= {in_red_in, in_green_in, in_blue_in};
      s1_col_r   <= vc_r;
      s1_last_r  <= op_emit && frame_end;
      s1_top_r   <= (out_row_r != '0);
      s1_bot_r   <= (out_row_r != h_last_r);
      s1_left_r  <= (out_col_r != '0);
      s1_right_r <= (out_col_r != w_last_r);
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= line_mem[vc_r];
    end
    if (s1_valid_r) begin
      line_mem[s1_col_r] <= wr_data;
    end
  end

  assign cur_word = s1_fwd_r ? fwd_data_r : rd_data_r;
  assign wr_data  = {s1_pix_r, cur_word[2*PIX_W-1:PIX_W]};

  always_comb begin
    new_col[0] = cur_word[PIX_W-1:0];
    new_col[1] = cur_word[2*PIX_W-1:PIX_W];
    new_col[2] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      win_l_r <= win_c_r;
      win_c_r <= new_col;
    end
  end

  assign row_ok = {s1_bot_r, 1'b1, s1_top_r};
  assign row_n  = 2'd1 + {1'b0, s1_top_r} + {1'b0, s1_bot_r};
  assign col_n  = 2'd1 + {1'b0, s1_left_r} + {1'b0, s1_right_r};

  always_comb begin
    sum_item.last  = s1_last_r;
    sum_item.count = {2'b00, row_n} * {2'b00, col_n};
    for (int k = 0; k < bblur_pkg::NUM_CH; k++) begin
      for (int i = 0; i < 3; i++) begin
        row_sum[i] = '0;
        if (row_ok[i]) begin
          row_sum[i] = SUM_W'(win_c_r[i][k*CH_W +: CH_W])
                       + (s1_left_r  ? SUM_W'(win_l_r[i][k*CH_W +: CH_W]) : '0)
                       + (s1_right_r ? SUM_W'(new_col[i][k*CH_W +: CH_W]) : '0);
        end
      end
      sum_item.sum[k] = row_sum[0] + row_sum[1] + row_sum[2];
    end
  end

  bblur_mean u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r && s1_emit_r),
    .in_item   (sum_item),
    .out_valid (mean_valid),
    .out_item  (mean_item),
    .inflight  (mean_inflight)
  );

  bblur_out_fifo #(
    .DEPTH (bblur_pkg::OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mean_valid),
    .push_item (mean_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .level     (fifo_level)
  );

  assign out_red_out    = out_item.chan[2];
  assign out_green_out  = out_item.chan[1];
  assign out_blue_out   = out_item.chan[0];
  assign out_frame_last = out_item.last;

endmodule
